>>> rtl/tcf_pkg.sv
// Shared types, constants and helpers for the tilt complementary filter.
// No dependencies; imported by tcf_lane and tilt_complementary_filter.
`timescale 1ns / 1ps

package tcf_pkg;

  // Vectoring rotations per atan2, limited by the angle table length
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;

  // Per-phase last step indexes for the lane step counter
  localparam logic [5:0] SqLast     = 6'd15;
  localparam logic [5:0] RootLast   = 6'd15;
  localparam logic [5:0] CordicLast =
      6'(((CordicSteps < AtanEntries) ? CordicSteps : AtanEntries) - 1);
  localparam logic [5:0] MulLast    = 6'd31;
  localparam logic [5:0] DivLast    = 6'd49;
  localparam logic [5:0] MixLast    = 6'd15;

  // 1000 ms * 131 counts per deg/s
  localparam logic [17:0] IncDivisor = 18'd131000;
  // 0.96 in unsigned Q0.16
  localparam logic [15:0] AlphaReset = 16'd62915;

  typedef enum logic [1:0] {
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_RANGE,
    CFG_ALPHA
  } cfg_index_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_START,
    TOP_RUN
  } top_state_e;

  typedef enum logic [3:0] {
    LANE_IDLE,
    LANE_SQ_A,
    LANE_SQ_B,
    LANE_ROOT,
    LANE_ROT,
    LANE_GMUL,
    LANE_GDIV,
    LANE_SUM,
    LANE_MIX,
    LANE_DONE
  } lane_state_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic        [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] drift_angle_x;
    logic signed [31:0] drift_angle_y;
  } out_item_t;

  // Work handed to one axis lane
  typedef struct packed {
    logic               start;
    logic        [1:0]  range_sel;
    logic        [15:0] alpha;
    logic        [31:0] dt;
    logic signed [16:0] diff;   // rate minus offset
    logic signed [16:0] num;    // atan2 numerator
    logic signed [15:0] sq_a;   // magnitude terms for the denominator
    logic signed [15:0] sq_b;
    logic signed [31:0] filt;
    logic signed [31:0] drift;
  } lane_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] filt;
    logic signed [31:0] drift;
  } lane_rsp_t;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest
  function automatic logic signed [24:0] atan_entry(input logic [4:0] idx);
    logic signed [24:0] v;
    case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = 53'sd2147483647;
    lo = -53'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

>>> rtl/tilt_complementary_filter.sv
// Top level of the two-axis tilt complementary filter.
// Depends on tcf_pkg and instantiates two tcf_lane units (roll and pitch).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one raw IMU
//   beat: three accel axes, two gyro rates and a millisecond timestamp.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns one beat
//   per input: filtered roll and pitch plus the gyro-only drift angles,
//   all Q16.16 degrees, saturated.
//   Configuration port (cfg_valid_i / cfg_ready_o) writes gyro offsets,
//   range code and blend weight; it is always ready. Write it only idle.
// Schedule:
//   Both axes run side by side in bit-serial lanes; the lane sequence is
//   2x16 square steps, 16 root steps, 16 CORDIC steps, 32 multiply steps,
//   50 divide steps, 1 sum and 16 blend steps. One beat is in flight at a
//   time: a new beat is not accepted until the previous result is loaded.
// Reset clears the angles, the timestamp history and restores the default
// configuration. When out_stall_i holds a result, the next beat may still be
// accepted and processed; it waits in the lanes until the output frees up.

module tilt_complementary_filter import tcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  top_state_e state_q, state_d;

  // configuration
  logic signed [15:0] off_x_q, off_y_q;
  logic [1:0]         range_q;
  logic [15:0]        alpha_q;

  // filter state
  logic signed [31:0] filt_x_q, filt_y_q, drift_x_q, drift_y_q;
  logic [31:0]        prev_time_q;
  logic               seen_first_q;

  // latched beat
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] diff_x_q, diff_y_q;
  logic [31:0]        dt_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  logic      in_acc, start, load, slot_free;
  lane_req_t req_x, req_y;
  lane_rsp_t rsp_x, rsp_y;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE:  if (in_acc) state_d = TOP_START;
      TOP_START: state_d = TOP_RUN;
      TOP_RUN:   if (load) state_d = TOP_IDLE;
      default:   state_d = TOP_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != TOP_IDLE);
    start      = (state_q == TOP_START);
    load       = (state_q == TOP_RUN) && rsp_x.done && rsp_y.done && slot_free;
  end

  // Lane requests: roll uses -ay over |ax,az|, pitch uses ax over |ay,az|
  always_comb begin
    req_x.start     = start;
    req_x.range_sel = range_q;
    req_x.alpha     = alpha_q;
    req_x.dt        = dt_q;
    req_x.diff      = diff_x_q;
    req_x.num       = 17'sd0 - {ay_q[15], ay_q};
    req_x.sq_a      = ax_q;
    req_x.sq_b      = az_q;
    req_x.filt      = filt_x_q;
    req_x.drift     = drift_x_q;

    req_y.start     = start;
    req_y.range_sel = range_q;
    req_y.alpha     = alpha_q;
    req_y.dt        = dt_q;
    req_y.diff      = diff_y_q;
    req_y.num       = {ax_q[15], ax_q};
    req_y.sq_a      = ay_q;
    req_y.sq_b      = az_q;
    req_y.filt      = filt_y_q;
    req_y.drift     = drift_y_q;
  end

  tcf_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_x),
    .rsp_o  (rsp_x)
  );

  tcf_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_y),
    .rsp_o  (rsp_y)
  );

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TOP_IDLE;
      off_x_q      <= '0;
      off_y_q      <= '0;
      range_q      <= '0;
      alpha_q      <= AlphaReset;
      filt_x_q     <= '0;
      filt_y_q     <= '0;
      drift_x_q    <= '0;
      drift_y_q    <= '0;
      prev_time_q  <= '0;
      seen_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_OFFSET_X: off_x_q <= cfg_data_i;
          CFG_OFFSET_Y: off_y_q <= cfg_data_i;
          CFG_RANGE:    range_q <= cfg_data_i[1:0];
          CFG_ALPHA:    alpha_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_time_q  <= in_data_i.time_ms;
        seen_first_q <= 1'b1;
      end
      if (load) begin
        filt_x_q    <= rsp_x.filt;
        filt_y_q    <= rsp_y.filt;
        drift_x_q   <= rsp_x.drift;
        drift_y_q   <= rsp_y.drift;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat capture and output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q     <= in_data_i.accel_x;
      ay_q     <= in_data_i.accel_y;
      az_q     <= in_data_i.accel_z;
      diff_x_q <= {in_data_i.rate_x[15], in_data_i.rate_x} - {off_x_q[15], off_x_q};
      diff_y_q <= {in_data_i.rate_y[15], in_data_i.rate_y} - {off_y_q[15], off_y_q};
      dt_q     <= seen_first_q ? 32'(in_data_i.time_ms - prev_time_q) : 32'd0;
    end
    if (load) begin
      out_data_q.angle_x       <= rsp_x.filt;
      out_data_q.angle_y       <= rsp_y.filt;
      out_data_q.drift_angle_x <= rsp_x.drift;
      out_data_q.drift_angle_y <= rsp_y.drift;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Both lanes run a fixed schedule from the same start
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_x.done == rsp_y.done)
    else $error("axis lanes out of step");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second beat taken while busy");

  a_first_dt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !seen_first_q |=> dt_q == 32'd0)
    else $error("nonzero dt on first sample");

  a_load_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == TOP_RUN))
    else $error("result loaded outside run");

endmodule

>>> rtl/tcf_lane.sv
// One axis of the tilt filter: serial squares, digit-by-digit root, CORDIC,
// serial gyro multiply and divide, then a serial blend. Uses tcf_pkg.
`timescale 1ns / 1ps

module tcf_lane import tcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_req_t req_i,
  output lane_rsp_t rsp_o
);

  lane_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;

  // shift-add multiplier: high part, low/multiplier part, multiplicand
  logic [33:0] mu_q, mu_d;
  logic [31:0] ml_q, ml_d;
  logic [32:0] mm_q, mm_d;
  logic        msgn_q, msgn_d;

  // root: radicand, remainder, root digits
  logic [31:0] rad_q, rad_d;
  logic [16:0] rr_q, rr_d;
  logic [15:0] rq_q, rq_d;

  // CORDIC
  logic signed [27:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [24:0] cz_q, cz_d;
  logic               czero_q, czero_d;
  logic signed [24:0] acc_q, acc_d;

  // divider remainder and dividend/quotient shift register
  logic [16:0] dr_q, dr_d;
  logic [49:0] dv_q, dv_d;

  logic signed [31:0] filt_q, filt_d, drift_q, drift_d;

  logic        last;
  logic [32:0] addend;
  logic [34:0] mt;
  logic [15:0] mag_a, mag_b, dmag;
  logic [17:0] prate;
  logic [18:0] r_sh, r_trial;
  logic        r_ge;
  logic [16:0] r_next;
  logic [15:0] q_next;
  logic [4:0]  sh;
  logic signed [27:0] xs, ys;
  logic signed [24:0] at;
  logic signed [27:0] cx_n, cy_n;
  logic signed [24:0] cz_n;
  logic [49:0] mprod;
  logic [17:0] d_sh;
  logic        d_ge;
  logic [50:0] inc;
  logic signed [31:0] gyro;
  logic [35:0] mix_sum;

  // Operand magnitudes and gyro rate times range factor
  assign mag_a = req_i.sq_a[15] ? 16'(~req_i.sq_a + 16'd1) : req_i.sq_a;
  assign mag_b = req_i.sq_b[15] ? 16'(~req_i.sq_b + 16'd1) : req_i.sq_b;
  assign dmag  = req_i.diff[16] ? 16'(~req_i.diff + 17'd1) : req_i.diff[15:0];
  assign prate = {2'b00, dmag}
               + (req_i.range_sel[0] ? {2'b00, dmag} : 18'd0)
               + (req_i.range_sel[1] ? {1'b0, dmag, 1'b0} : 18'd0);

  // Multiplier step: one multiplier bit per cycle
  assign addend = ml_q[0] ? mm_q : 33'd0;
  assign mt = {msgn_q & mu_q[33], mu_q} + {{2{msgn_q & addend[32]}}, addend};

  // Root step: two radicand bits per cycle
  assign r_sh    = {rr_q, rad_q[31:30]};
  assign r_trial = {1'b0, rq_q, 2'b01};
  assign r_ge    = (r_sh >= r_trial);
  assign r_next  = r_ge ? 17'(r_sh - r_trial) : r_sh[16:0];
  assign q_next  = {rq_q[14:0], r_ge};

  // CORDIC vectoring step
  assign sh = cnt_q[4:0];
  assign xs = cx_q >>> sh;
  assign ys = cy_q >>> sh;
  assign at = atan_entry(sh);
  always_comb begin
    if (!cy_q[27]) begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + at;
    end else begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - at;
    end
  end

  // Full product of rate and dt on the last multiply step
  assign mprod = {mt[18:0], ml_q[31:1]};

  // Restoring divide step: one quotient bit per cycle
  assign d_sh = {dr_q, dv_q[49]};
  assign d_ge = (d_sh >= IncDivisor);

  // Signed increment and gyro angle
  assign inc  = req_i.diff[16] ? 51'(~{1'b0, dv_q} + 51'd1) : {1'b0, dv_q};
  assign gyro = sat32($signed({{21{filt_q[31]}}, filt_q}) + $signed({{2{inc[50]}}, inc}));

  // Blend: accel + round(alpha * (gyro - accel) / 2^16)
  assign mix_sum = {{2{mt[34]}}, mt[34:1]} + {35'd0, mt[0]}
                 + {{11{acc_q[24]}}, acc_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      LANE_IDLE, LANE_DONE: if (req_i.start) state_d = LANE_SQ_A;
      LANE_SQ_A: if (cnt_q == SqLast) state_d = LANE_SQ_B;
      LANE_SQ_B: if (cnt_q == SqLast) state_d = LANE_ROOT;
      LANE_ROOT: if (cnt_q == RootLast) state_d = LANE_ROT;
      LANE_ROT:  if (cnt_q == CordicLast) state_d = LANE_GMUL;
      LANE_GMUL: if (cnt_q == MulLast) state_d = LANE_GDIV;
      LANE_GDIV: if (cnt_q == DivLast) state_d = LANE_SUM;
      LANE_SUM:  state_d = LANE_MIX;
      LANE_MIX:  if (cnt_q == MixLast) state_d = LANE_DONE;
      default:   state_d = LANE_IDLE;
    endcase
  end

  assign last  = (state_d != state_q);
  assign cnt_d = last ? 6'd0 : 6'(cnt_q + 6'd1);

  // Datapath updates per phase
  always_comb begin
    mu_d = mu_q;  ml_d = ml_q;  mm_d = mm_q;  msgn_d = msgn_q;
    rad_d = rad_q;  rr_d = rr_q;  rq_d = rq_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;  czero_d = czero_q;  acc_d = acc_q;
    dr_d = dr_q;  dv_d = dv_q;  filt_d = filt_q;  drift_d = drift_q;
    case (state_q)
      LANE_IDLE, LANE_DONE: begin
        if (req_i.start) begin
          mm_d = {17'd0, mag_a};
          ml_d = {16'd0, mag_a};
          mu_d = '0;
          msgn_d = 1'b0;
        end
      end
      LANE_SQ_A: begin
        mu_d = mt[34:1];
        ml_d = {mt[0], ml_q[31:1]};
        if (last) begin
          rad_d = {mt[16:0], ml_q[31:17]};
          mm_d = {17'd0, mag_b};
          ml_d = {16'd0, mag_b};
          mu_d = '0;
        end
      end
      LANE_SQ_B: begin
        mu_d = mt[34:1];
        ml_d = {mt[0], ml_q[31:1]};
        if (last) begin
          rad_d = rad_q + {mt[16:0], ml_q[31:17]};
          rr_d = '0;
          rq_d = '0;
        end
      end
      LANE_ROOT: begin
        rad_d = {rad_q[29:0], 2'b00};
        rr_d = r_next;
        rq_d = q_next;
        if (last) begin
          cx_d = $signed({4'd0, q_next, 8'd0});
          cy_d = $signed({{3{req_i.num[16]}}, req_i.num, 8'd0});
          cz_d = '0;
          czero_d = (q_next == 16'd0) && (req_i.num == 17'sd0);
        end
      end
      LANE_ROT: begin
        cx_d = cx_n;
        cy_d = cy_n;
        cz_d = cz_n;
        if (last) begin
          acc_d = czero_q ? 25'sd0 : cz_n;
          mm_d = {15'd0, prate};
          ml_d = req_i.dt;
          mu_d = '0;
          msgn_d = 1'b0;
        end
      end
      LANE_GMUL: begin
        mu_d = mt[34:1];
        ml_d = {mt[0], ml_q[31:1]};
        if (last) begin
          dr_d = {1'b0, mprod[49:34]};
          dv_d = {mprod[33:0], 16'd0};
        end
      end
      LANE_GDIV: begin
        dr_d = d_ge ? 17'(d_sh - IncDivisor) : d_sh[16:0];
        dv_d = {dv_q[48:0], d_ge};
      end
      LANE_SUM: begin
        drift_d = sat32($signed({{21{drift_q[31]}}, drift_q})
                      + $signed({{2{inc[50]}}, inc}));
        mm_d = 33'({gyro[31], gyro} - {{8{acc_q[24]}}, acc_q});
        ml_d = {16'd0, req_i.alpha};
        mu_d = '0;
        msgn_d = 1'b1;
      end
      LANE_MIX: begin
        mu_d = mt[34:1];
        ml_d = {mt[0], ml_q[31:1]};
        if (last) begin
          filt_d = sat32($signed({{17{mix_sum[35]}}, mix_sum}));
        end
      end
      default: ;
    endcase
  end

  // Lane state and step counter, reset to idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Finished angles hold in DONE until the next start, which loads them from the request
  always_ff @(posedge clk_i) begin
    mu_q <= mu_d;  ml_q <= ml_d;  mm_q <= mm_d;  msgn_q <= msgn_d;
    rad_q <= rad_d;  rr_q <= rr_d;  rq_q <= rq_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  czero_q <= czero_d;  acc_q <= acc_d;
    dr_q <= dr_d;  dv_q <= dv_d;
    if ((state_q == LANE_IDLE || state_q == LANE_DONE) && req_i.start) begin
      filt_q  <= req_i.filt;
      drift_q <= req_i.drift;
    end else begin
      filt_q  <= filt_d;
      drift_q <= drift_d;
    end
  end

  assign rsp_o.done  = (state_q == LANE_DONE);
  assign rsp_o.filt  = filt_q;
  assign rsp_o.drift = drift_q;

endmodule
